// ===== hdl/flux_pi_pll_bitcell_recovery_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the flux bitcell recovery unit
// Shared helpers that clock on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FLUX_PI_PLL_BITCELL_RECOVERY_UNIT_DEFINES_SVH
`define FLUX_PI_PLL_BITCELL_RECOVERY_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FPBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpbr check failed");

// Next-cycle implication.
`define FPBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpbr check failed");

`endif

// ===== hdl/fpbr_pkg.sv =====
// ---------------------------------------------------------------------------
// Flux bitcell recovery package
// Types and constants shared by the controller and the datapath.
// ---------------------------------------------------------------------------
package fpbr_pkg;

  localparam logic [16:0] PERIOD_NOM = 17'd65536;
  localparam logic [16:0] PERIOD_MIN = 17'd57344;
  localparam logic [16:0] PERIOD_MAX = 17'd73728;
  localparam logic [10:0] ZERO_RUN_MAX = 11'd1248;

  localparam logic [2:0] REG_BITCELL = 3'd0;
  localparam logic [2:0] REG_PMUL    = 3'd1;
  localparam logic [2:0] REG_PDIV    = 3'd2;
  localparam logic [2:0] REG_IMUL    = 3'd3;
  localparam logic [2:0] REG_IDIV    = 3'd4;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_TCALC  = 14'b00000000000010,
    S_EDGE   = 14'b00000000000100,
    S_CHECK  = 14'b00000000001000,
    S_COUNT  = 14'b00000000010000,
    S_PUSH   = 14'b00000000100000,
    S_ERR    = 14'b00000001000000,
    S_INTEG  = 14'b00000010000000,
    S_PMUL   = 14'b00000100000000,
    S_PDIV   = 14'b00001000000000,
    S_IMUL   = 14'b00010000000000,
    S_IDIV   = 14'b00100000000000,
    S_UPDATE = 14'b01000000000000,
    S_FLUSH  = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic ld_in;
    logic ld_t;
    logic ld_edge;
    logic cnt_init;
    logic cnt_step;
    logic push;
    logic ld_err;
    logic ld_int;
    logic start_p;
    logic start_i;
    logic ld_qp;
    logic ld_qi;
    logic commit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic runt;
    logic cnt_more;
    logic push_word;
    logic rem_last;
    logic out_free;
    logic div_busy;
  } sts_t;

endpackage

// ===== hdl/fpbr_div.sv =====
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fpbr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [47:0] quotient
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[47]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd47;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/fpbr_ctrl.sv =====
// ---------------------------------------------------------------------------
// Flux bitcell recovery controller
// Sequences one input word through timing, bit shifting and loop update, or a flush.
// ---------------------------------------------------------------------------
`include "flux_pi_pll_bitcell_recovery_unit_defines.svh"

module fpbr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_mode,
  output logic            in_stall,
  input  fpbr_pkg::sts_t  sts,
  output fpbr_pkg::cmd_t  cmd
);

  fpbr_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      fpbr_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = in_mode ? fpbr_pkg::S_FLUSH : fpbr_pkg::S_TCALC;
        end
      end
      fpbr_pkg::S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = fpbr_pkg::S_IDLE;
        end
      end
      fpbr_pkg::S_TCALC: begin
        cmd.ld_t  = 1'b1;
        state_nxt = fpbr_pkg::S_EDGE;
      end
      fpbr_pkg::S_EDGE: begin
        cmd.ld_edge = 1'b1;
        state_nxt   = fpbr_pkg::S_CHECK;
      end
      fpbr_pkg::S_CHECK: begin
        cmd.cnt_init = 1'b1;
        state_nxt    = sts.runt ? fpbr_pkg::S_IDLE : fpbr_pkg::S_COUNT;
      end
      fpbr_pkg::S_COUNT: begin
        cmd.cnt_step = 1'b1;
        if (!sts.cnt_more) begin
          state_nxt = fpbr_pkg::S_PUSH;
        end
      end
      fpbr_pkg::S_PUSH: begin
        if (!sts.push_word || sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.rem_last) begin
            state_nxt = fpbr_pkg::S_ERR;
          end
        end
      end
      fpbr_pkg::S_ERR: begin
        cmd.ld_err = 1'b1;
        state_nxt  = fpbr_pkg::S_INTEG;
      end
      fpbr_pkg::S_INTEG: begin
        cmd.ld_int = 1'b1;
        state_nxt  = fpbr_pkg::S_PMUL;
      end
      fpbr_pkg::S_PMUL: begin
        cmd.start_p = 1'b1;
        state_nxt   = fpbr_pkg::S_PDIV;
      end
      fpbr_pkg::S_PDIV: begin
        if (!sts.div_busy) begin
          cmd.ld_qp = 1'b1;
          state_nxt = fpbr_pkg::S_IMUL;
        end
      end
      fpbr_pkg::S_IMUL: begin
        cmd.start_i = 1'b1;
        state_nxt   = fpbr_pkg::S_IDIV;
      end
      fpbr_pkg::S_IDIV: begin
        if (!sts.div_busy) begin
          cmd.ld_qi = 1'b1;
          state_nxt = fpbr_pkg::S_UPDATE;
        end
      end
      fpbr_pkg::S_UPDATE: begin
        cmd.commit = 1'b1;
        state_nxt  = fpbr_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fpbr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpbr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != fpbr_pkg::S_IDLE);

  `FPBR_ASSERT_NOW(a_word_needs_room, cmd.push && sts.push_word, sts.out_free)
  `FPBR_ASSERT_NEXT(a_pdiv_to_imul, cmd.ld_qp, state_r == fpbr_pkg::S_IMUL)
  `FPBR_ASSERT_NOW(a_one_start, cmd.start_p || cmd.start_i, !sts.div_busy)

endmodule

// ===== hdl/fpbr_dp.sv =====
// ---------------------------------------------------------------------------
// Flux bitcell recovery datapath
// Holds loop state, registers, bit shifter, output word and the divider.
// ---------------------------------------------------------------------------
`include "flux_pi_pll_bitcell_recovery_unit_defines.svh"

module fpbr_dp #(
  parameter int BUF_WORDS  = 256,
  parameter int LEAD_ZEROS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fpbr_pkg::cmd_t cmd,
  output fpbr_pkg::sts_t sts,
  input  logic [15:0]    in_sample_time,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_word,
  output logic [7:0]     out_word_index,
  output logic [31:0]    out_bits_total,
  output logic           out_last
);

  localparam int WIDX_W = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
  localparam logic [WIDX_W:0] WIDX_TOP = (WIDX_W + 1)'(BUF_WORDS - 1);
  localparam logic signed [17:0] PERIOD_NOM_S = {1'b0, fpbr_pkg::PERIOD_NOM};
  localparam logic signed [17:0] PERIOD_MIN_S = {1'b0, fpbr_pkg::PERIOD_MIN};
  localparam logic signed [17:0] PERIOD_MAX_S = {1'b0, fpbr_pkg::PERIOD_MAX};

  logic [14:0] bitcell_r;
  logic [15:0] pmul_r, pdiv_r, imul_r, idiv_r;

  logic [15:0] sample_r;
  logic [16:0] period_r;
  logic signed [31:0] integ_r;
  logic [15:0] ls_r;
  logic [31:0] cle_r, pp_r, bc_r, sw_r;
  logic        first_r;
  logic [WIDX_W-1:0] widx_r;
  logic [31:0] t_r, edge_r, left_r;
  logic [10:0] z_r, rem_r;
  logic signed [31:0] err_r;
  logic        neg_r;
  logic signed [48:0] qp_r, qi_r;

  logic        ov_r;
  logic [31:0] ow_r, ot_r;
  logic [7:0]  oi_r;
  logic        ol_r;

  logic [15:0] ls_eff, dur;
  logic [31:0] cle_eff, pp_eff;
  logic [31:0] sw_nxt, bc_nxt;
  logic [10:0] rem_dec;
  logic signed [32:0] acc;
  logic signed [48:0] prod;
  logic [48:0] mag;
  logic [15:0] dvs;
  logic        div_start, div_busy;
  logic [47:0] quo;
  logic signed [49:0] np;
  logic [16:0] np_clamp;
  logic [WIDX_W:0] widx_ext;
  logic [16:0] widx_wide;
  logic        out_free;

  always_comb begin
    if (first_r) begin
      ls_eff  = 16'(sample_r - 16'(32'(LEAD_ZEROS) * {17'd0, bitcell_r}));
      cle_eff = '0;
      pp_eff  = t_r >> 1;
    end else begin
      ls_eff  = ls_r;
      cle_eff = cle_r;
      pp_eff  = pp_r;
    end
    dur = sample_r - ls_eff;
  end

  assign sw_nxt  = {sw_r[30:0], (rem_r == 11'd1)};
  assign bc_nxt  = bc_r + 32'd1;
  assign rem_dec = rem_r - 11'd1;
  assign acc     = 33'(integ_r) + 33'(err_r);

  always_comb begin
    if (cmd.start_p) begin
      prod = 49'(err_r) * $signed({33'd0, pmul_r});
      dvs  = (pdiv_r == 16'd0) ? 16'd1 : pdiv_r;
    end else begin
      prod = 49'(integ_r) * $signed({33'd0, imul_r});
      dvs  = (idiv_r == 16'd0) ? 16'd1 : idiv_r;
    end
    mag = prod[48] ? 49'(-prod) : 49'(prod);
  end

  assign div_start = cmd.start_p || cmd.start_i;

  fpbr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag[47:0]),
    .divisor  (dvs),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    np = 50'(PERIOD_NOM_S) + 50'(qp_r) + 50'(qi_r);
    if (np < 50'(PERIOD_MIN_S)) begin
      np_clamp = fpbr_pkg::PERIOD_MIN;
    end else if (np > 50'(PERIOD_MAX_S)) begin
      np_clamp = fpbr_pkg::PERIOD_MAX;
    end else begin
      np_clamp = np[16:0];
    end
  end

  assign widx_ext  = {1'b0, widx_r};
  assign widx_wide = 17'(widx_ext);
  assign out_free  = !ov_r || !out_stall;

  always_comb begin
    sts.runt      = (edge_r - cle_r) < t_r;
    sts.cnt_more  = (z_r < fpbr_pkg::ZERO_RUN_MAX) && ((edge_r - left_r) > t_r);
    sts.push_word = (bc_r[4:0] == 5'd31);
    sts.rem_last  = (rem_r == 11'd1);
    sts.out_free  = out_free;
    sts.div_busy  = div_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitcell_r <= 15'd144;
      pmul_r    <= 16'd1;
      pdiv_r    <= 16'd16;
      imul_r    <= 16'd1;
      idiv_r    <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpbr_pkg::REG_BITCELL: bitcell_r <= cfg_data[14:0];
        fpbr_pkg::REG_PMUL:    pmul_r    <= cfg_data;
        fpbr_pkg::REG_PDIV:    pdiv_r    <= cfg_data;
        fpbr_pkg::REG_IMUL:    imul_r    <= cfg_data;
        fpbr_pkg::REG_IDIV:    idiv_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.flush) begin
      period_r <= fpbr_pkg::PERIOD_NOM;
      integ_r  <= '0;
      ls_r     <= '0;
      cle_r    <= '0;
      pp_r     <= '0;
      bc_r     <= '0;
      sw_r     <= '1;
      first_r  <= 1'b1;
      widx_r   <= '0;
    end else begin
      if (cmd.ld_edge) begin
        ls_r    <= ls_eff;
        cle_r   <= cle_eff;
        pp_r    <= pp_eff;
        first_r <= 1'b0;
      end
      if (cmd.push) begin
        sw_r <= sw_nxt;
        bc_r <= bc_nxt;
        if (sts.push_word) begin
          widx_r <= (widx_ext == WIDX_TOP) ? '0 : WIDX_W'(widx_ext + 1'b1);
        end
      end
      if (cmd.ld_int) begin
        if (acc > 33'sh0_7FFF_FFFF) begin
          integ_r <= 32'sh7FFF_FFFF;
        end else if (acc < -33'sh0_8000_0000) begin
          integ_r <= 32'sh8000_0000;
        end else begin
          integ_r <= acc[31:0];
        end
      end
      if (cmd.commit) begin
        period_r <= np_clamp;
        cle_r    <= left_r;
        pp_r     <= edge_r;
        ls_r     <= sample_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      sample_r <= in_sample_time;
    end
    if (cmd.ld_t) begin
      t_r <= {17'd0, bitcell_r} * {15'd0, period_r};
    end
    if (cmd.ld_edge) begin
      edge_r <= pp_eff + {dur, 16'd0};
      left_r <= cle_eff + t_r;
    end
    if (cmd.cnt_init) begin
      z_r <= '0;
    end
    if (cmd.cnt_step) begin
      if (sts.cnt_more) begin
        left_r <= left_r + t_r;
        z_r    <= z_r + 11'd1;
      end else begin
        rem_r <= z_r + 11'd1;
      end
    end
    if (cmd.push) begin
      rem_r <= rem_dec;
    end
    if (cmd.ld_err) begin
      err_r <= $signed(edge_r - (left_r + (t_r >> 1)));
    end
    if (div_start) begin
      neg_r <= prod[48];
    end
    if (cmd.ld_qp) begin
      qp_r <= neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
    if (cmd.ld_qi) begin
      qi_r <= neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.flush || (cmd.push && sts.push_word)) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (cmd.flush) begin
      ow_r <= sw_r << (5'(-bc_r[4:0]));
      oi_r <= widx_wide[7:0];
      ot_r <= bc_r;
      ol_r <= 1'b1;
    end else if (cmd.push && sts.push_word) begin
      ow_r <= sw_nxt;
      oi_r <= widx_wide[7:0];
      ot_r <= bc_nxt;
      ol_r <= (rem_dec < 11'd32);
    end
  end

  assign out_valid      = ov_r;
  assign out_word       = ow_r;
  assign out_word_index = oi_r;
  assign out_bits_total = ot_r;
  assign out_last       = ol_r;

  `FPBR_ASSERT_NEXT(a_flush_restarts, cmd.flush, bc_r == 32'd0 && first_r)
  `FPBR_ASSERT_NEXT(a_push_counts, cmd.push && !cmd.flush, bc_r == $past(bc_r) + 32'd1)
  `FPBR_ASSERT_NOW(a_period_range, 1'b1,
                   period_r >= fpbr_pkg::PERIOD_MIN && period_r <= fpbr_pkg::PERIOD_MAX)

endmodule

// ===== hdl/flux_pi_pll_bitcell_recovery_unit.sv =====
// ---------------------------------------------------------------------------
// Flux bitcell recovery unit
// PI phase-locked loop that turns flux-pulse timestamps into 32-bit words.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake           Word
// in       input      in_valid/in_stall   in_mode, in_sample_time
// out      output     out_valid/out_stall out_word, out_word_index,
//                                         out_bits_total, out_last
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A pulse's time from acceptance to the next accept grows with Z, the number
// of empty bitcells, and B = Z + 1, the bits shifted; the shared divider,
// used twice, sets most of it. A runt pulse skips the count, shift and loop
// update, and a flush waits only for a free output.
// Reset is synchronous and active low and restores every loop state.
// A stalled output holds the shifter until the pending word is taken.
// ---------------------------------------------------------------------------
module flux_pi_pll_bitcell_recovery_unit #(
  parameter int BUF_WORDS  = 256,
  parameter int LEAD_ZEROS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_sample_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic [7:0]  out_word_index,
  output logic [31:0] out_bits_total,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fpbr_pkg::cmd_t cmd;
  fpbr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fpbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpbr_dp #(
    .BUF_WORDS  (BUF_WORDS),
    .LEAD_ZEROS (LEAD_ZEROS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample_time (in_sample_time),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .out_word_index (out_word_index),
    .out_bits_total (out_bits_total),
    .out_last       (out_last)
  );

endmodule
